// ===== src/region_boundary_marker_defines.svh =====
// ----------------------------------------------------------------------------
// Region boundary marker assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef REGION_BOUNDARY_MARKER_DEFINES_SVH
`define REGION_BOUNDARY_MARKER_DEFINES_SVH

// Same-cycle implication
`define RBM_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication
`define RBM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== src/rbm_pkg.sv =====
// ----------------------------------------------------------------------------
// Region boundary marker package
// Field widths, codes and the stage control struct shared by the interface, scan, edge and checker files.
// ----------------------------------------------------------------------------
package rbm_pkg;

    localparam int LABEL_W    = 24;
    localparam int PIX_X_W    = 11;
    localparam int PIX_Y_W    = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam int FRAME_WIDTH_RESET           = 2048;
    localparam logic [15:0] FRAME_HEIGHT_RESET = 16'd1024;

    localparam logic MODE_LABEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic emit;
        logic col_first;
        logic col_wrap;
        logic has_up;
        logic has_down;
        logic frame_last;
    } rbm_ctrl_t;

endpackage

// ===== src/rbm_if.sv =====
// ----------------------------------------------------------------------------
// Region boundary marker channels
// Valid/ready item channels for label input and boundary results.
// ----------------------------------------------------------------------------
interface rbm_in_if;
    import rbm_pkg::*;

    logic               valid;
    logic               ready;
    logic               mode;
    logic [LABEL_W-1:0] label;

    modport source (output valid, output mode, output label, input ready);
    modport sink   (input valid, input mode, input label, output ready);
endinterface

interface rbm_out_if;
    import rbm_pkg::*;

    logic               valid;
    logic               ready;
    logic               outline;
    logic [PIX_X_W-1:0] pixel_x;
    logic [PIX_Y_W-1:0] pixel_y;
    logic               frame_last;

    modport source (output valid, output outline, output pixel_x, output pixel_y,
                    output frame_last, input ready);
    modport sink   (input valid, input outline, input pixel_x, input pixel_y,
                    input frame_last, output ready);
endinterface

// ===== src/rbm_row_mem.sv =====
// ----------------------------------------------------------------------------
// Region boundary marker row memory
// Three rows of labels, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module rbm_row_mem #(
    parameter int MAX_WIDTH  = 2048,
    parameter int LABEL_BITS = 24,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int AW = CW + 2
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  logic [LABEL_BITS-1:0] wdata,
    input  logic                  re,
    input  logic [AW-1:0]         raddr_a,
    input  logic [AW-1:0]         raddr_b,
    output logic [LABEL_BITS-1:0] rdata_a,
    output logic [LABEL_BITS-1:0] rdata_b
);
    localparam int DEPTH = 3 * (1 << CW);

    logic [LABEL_BITS-1:0] mem [DEPTH];
    logic [LABEL_BITS-1:0] rdata_a_reg;
    logic [LABEL_BITS-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== src/rbm_scan.sv =====
// ----------------------------------------------------------------------------
// Region boundary marker scan control
// Raster position, row slots, wrap labels, memory access and stage register.
// ----------------------------------------------------------------------------
module rbm_scan #(
    parameter int MAX_WIDTH  = 2048,
    parameter int LABEL_BITS = 24,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int AW = CW + 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    rbm_in_if.sink                          labels,
    input  logic                            cfg_we,
    input  logic [rbm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rbm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            out_free,
    output logic                            mem_we,
    output logic [AW-1:0]                   mem_waddr,
    output logic [LABEL_BITS-1:0]           mem_wdata,
    output logic                            mem_re,
    output logic [AW-1:0]                   mem_raddr_a,
    output logic [AW-1:0]                   mem_raddr_b,
    output rbm_pkg::rbm_ctrl_t              p1_ctrl,
    output logic [CW-1:0]                   p1_x,
    output logic [rbm_pkg::PIX_Y_W-1:0]     p1_y,
    output logic [LABEL_BITS-1:0]           p1_down,
    output logic [LABEL_BITS-1:0]           p1_first,
    output logic [LABEL_BITS-1:0]           p1_last
);
    import rbm_pkg::*;

    localparam int WV = (CW + 1 > 12) ? CW + 1 : 12;
    localparam int WIDTH_RESET =
        (FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RESET;

    logic [CW-1:0]      col_reg;
    logic [PIX_Y_W-1:0] row_reg;
    logic [CW-1:0]      drain_reg;
    logic               pending_reg;
    logic [CW-1:0]      wm1_reg;
    logic [PIX_Y_W-1:0] hm1_reg;
    logic [1:0]         cur_slot_reg;
    logic [1:0]         prev_slot_reg;
    logic [1:0]         prev2_slot_reg;

    logic [LABEL_BITS-1:0] cur_first_reg;
    logic [LABEL_BITS-1:0] prev_first_reg;
    logic [LABEL_BITS-1:0] prev_last_reg;

    rbm_ctrl_t             p1_ctrl_reg;
    rbm_ctrl_t             ctrl_next;
    logic [CW-1:0]         p1_x_reg;
    logic [PIX_Y_W-1:0]    p1_y_reg;
    logic [PIX_Y_W-1:0]    y_next;
    logic [LABEL_BITS-1:0] p1_down_reg;
    logic [LABEL_BITS-1:0] p1_first_reg;
    logic [LABEL_BITS-1:0] p1_last_reg;

    logic                  acc;
    logic                  is_label;
    logic                  emit_label;
    logic                  emit_drain;
    logic                  col_end;
    logic                  row_end;
    logic                  drain_end;
    logic [CW-1:0]         pos;
    logic                  pos_end;
    logic [LABEL_BITS-1:0] lab;
    logic [WV-1:0]         wv;
    logic [CW-1:0]         wm1_next;
    logic [PIX_Y_W-1:0]    hm1_next;

    assign labels.ready = !p1_ctrl_reg.emit || out_free;
    assign acc          = labels.valid && labels.ready;
    assign is_label     = labels.mode == MODE_LABEL;
    assign lab          = LABEL_BITS'(labels.label);
    assign col_end      = col_reg == wm1_reg;
    assign row_end      = row_reg == hm1_reg;
    assign drain_end    = drain_reg == wm1_reg;
    assign emit_label   = is_label && (row_reg != '0);
    assign emit_drain   = (labels.mode == MODE_DRAIN) && pending_reg;
    assign pos          = is_label ? col_reg : drain_reg;
    assign pos_end      = is_label ? col_end : drain_end;

    assign mem_we      = acc && is_label;
    assign mem_waddr   = {cur_slot_reg, col_reg};
    assign mem_wdata   = lab;
    assign mem_re      = acc && (emit_label || emit_drain);
    assign mem_raddr_a = {prev_slot_reg, CW'(pos + 1'b1)};
    assign mem_raddr_b = {prev2_slot_reg, pos};

    always_comb
    begin
        ctrl_next.emit       = emit_label || emit_drain;
        ctrl_next.col_first  = pos == '0;
        ctrl_next.col_wrap   = pos_end;
        ctrl_next.has_up     = is_label ? (row_reg > 16'd1) : (hm1_reg != '0);
        ctrl_next.has_down   = is_label;
        ctrl_next.frame_last = !is_label && drain_end;
        y_next               = is_label ? row_reg - 16'd1 : hm1_reg;
    end

    // clamp register writes to the legal range
    always_comb
    begin
        wv = WV'(cfg_data[11:0]);
        if (wv == '0)
        begin
            wm1_next = '0;
        end
        else if (wv > WV'(MAX_WIDTH))
        begin
            wm1_next = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            wm1_next = CW'(wv - 1'b1);
        end
        hm1_next = (cfg_data == '0) ? '0 : cfg_data - 16'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            drain_reg      <= '0;
            pending_reg    <= 1'b0;
            wm1_reg        <= CW'(WIDTH_RESET - 1);
            hm1_reg        <= FRAME_HEIGHT_RESET - 16'd1;
            cur_slot_reg   <= 2'd0;
            prev_slot_reg  <= 2'd1;
            prev2_slot_reg <= 2'd2;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  wm1_reg <= wm1_next;
                REG_FRAME_HEIGHT: hm1_reg <= hm1_next;
                default:          ;
            endcase
            col_reg     <= '0;
            row_reg     <= '0;
            drain_reg   <= '0;
            pending_reg <= 1'b0;
        end
        else if (acc)
        begin
            if (is_label)
            begin
                pending_reg <= 1'b0;
                if (col_end)
                begin
                    col_reg        <= '0;
                    cur_slot_reg   <= prev2_slot_reg;
                    prev_slot_reg  <= cur_slot_reg;
                    prev2_slot_reg <= prev_slot_reg;
                    if (row_end)
                    begin
                        row_reg     <= '0;
                        drain_reg   <= '0;
                        pending_reg <= 1'b1;
                    end
                    else
                    begin
                        row_reg <= row_reg + 16'd1;
                    end
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            else if (pending_reg)
            begin
                if (drain_end)
                begin
                    drain_reg   <= '0;
                    pending_reg <= 1'b0;
                end
                else
                begin
                    drain_reg <= drain_reg + 1'b1;
                end
            end
        end
    end

    // wrap labels of the row being written and of the row above
    always_ff @(posedge clk)
    begin
        if (acc && is_label && !cfg_we)
        begin
            if (col_reg == '0)
            begin
                cur_first_reg <= lab;
            end
            if (col_end)
            begin
                prev_first_reg <= (col_reg == '0) ? lab : cur_first_reg;
                prev_last_reg  <= lab;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_ctrl_reg <= '0;
        end
        else if (acc)
        begin
            p1_ctrl_reg <= ctrl_next;
        end
        else if (out_free)
        begin
            p1_ctrl_reg.emit <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            p1_x_reg     <= pos;
            p1_y_reg     <= y_next;
            p1_down_reg  <= lab;
            p1_first_reg <= prev_first_reg;
            p1_last_reg  <= prev_last_reg;
        end
    end

    assign p1_ctrl  = p1_ctrl_reg;
    assign p1_x     = p1_x_reg;
    assign p1_y     = p1_y_reg;
    assign p1_down  = p1_down_reg;
    assign p1_first = p1_first_reg;
    assign p1_last  = p1_last_reg;

endmodule

// ===== src/rbm_edge.sv =====
// ----------------------------------------------------------------------------
// Region boundary marker edge stage
// Neighbor window, label compare and the result output register.
// ----------------------------------------------------------------------------
module rbm_edge #(
    parameter int MAX_WIDTH  = 2048,
    parameter int LABEL_BITS = 24,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rbm_pkg::rbm_ctrl_t          p1_ctrl,
    input  logic [CW-1:0]               p1_x,
    input  logic [rbm_pkg::PIX_Y_W-1:0] p1_y,
    input  logic [LABEL_BITS-1:0]       p1_down,
    input  logic [LABEL_BITS-1:0]       p1_first,
    input  logic [LABEL_BITS-1:0]       p1_last,
    input  logic [LABEL_BITS-1:0]       rdata_a,
    input  logic [LABEL_BITS-1:0]       rdata_b,
    output logic                        out_free,
    rbm_out_if.source                   results
);
    import rbm_pkg::*;

    logic [LABEL_BITS-1:0] win_me_reg;
    logic [LABEL_BITS-1:0] win_left_reg;
    logic [LABEL_BITS-1:0] me;
    logic [LABEL_BITS-1:0] left;
    logic [LABEL_BITS-1:0] right;
    logic                  fire;
    logic                  outline_next;

    logic               out_valid_reg;
    logic               out_outline_reg;
    logic [PIX_X_W-1:0] out_x_reg;
    logic [PIX_Y_W-1:0] out_y_reg;
    logic               out_last_reg;

    assign out_free = !out_valid_reg || results.ready;
    assign fire     = p1_ctrl.emit && out_free;

    always_comb
    begin
        me    = p1_ctrl.col_first ? p1_first : win_me_reg;
        left  = p1_ctrl.col_first ? p1_last : win_left_reg;
        right = p1_ctrl.col_wrap ? p1_first : rdata_a;
        outline_next = (left != me) || (right != me)
                    || (p1_ctrl.has_up && (rdata_b != me))
                    || (p1_ctrl.has_down && (p1_down != me));
    end

    // advance the window by one column
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            win_left_reg    <= me;
            win_me_reg      <= right;
            out_outline_reg <= outline_next;
            out_x_reg       <= PIX_X_W'(p1_x);
            out_y_reg       <= p1_y;
            out_last_reg    <= p1_ctrl.frame_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.outline    = out_outline_reg;
    assign results.pixel_x    = out_x_reg;
    assign results.pixel_y    = out_y_reg;
    assign results.frame_last = out_last_reg;

endmodule

// ===== src/region_boundary_marker.sv =====
// Path: an item that releases a result is registered in the scan stage, and the result
//   moves into the edge output register once that is free; from there it can be taken.
// Throughput: 1 item per cycle unless stalled; per item at most one row-memory write and two reads.
// Stall: labels.ready drops only while a result waits and the edge stage is full.
// Reset: rst_n clears position, drain state and valid flags at once; the row memory
//   holds no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
// Region boundary marker
// Marks pixels of a raster label stream whose four-neighbor labels differ.
// ----------------------------------------------------------------------------
module region_boundary_marker #(
    parameter int MAX_WIDTH  = 2048,
    parameter int LABEL_BITS = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    rbm_in_if.sink                         labels,
    rbm_out_if.source                      results,
    input  logic                           cfg_we,
    input  logic [rbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rbm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rbm_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int AW = CW + 2;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [LABEL_BITS-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr_a;
    logic [AW-1:0]         mem_raddr_b;
    logic [LABEL_BITS-1:0] mem_rdata_a;
    logic [LABEL_BITS-1:0] mem_rdata_b;

    rbm_ctrl_t             p1_ctrl;
    logic [CW-1:0]         p1_x;
    logic [PIX_Y_W-1:0]    p1_y;
    logic [LABEL_BITS-1:0] p1_down;
    logic [LABEL_BITS-1:0] p1_first;
    logic [LABEL_BITS-1:0] p1_last;
    logic                  out_free;

    rbm_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .LABEL_BITS (LABEL_BITS)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .labels      (labels),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_free    (out_free),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr_a (mem_raddr_a),
        .mem_raddr_b (mem_raddr_b),
        .p1_ctrl     (p1_ctrl),
        .p1_x        (p1_x),
        .p1_y        (p1_y),
        .p1_down     (p1_down),
        .p1_first    (p1_first),
        .p1_last     (p1_last)
    );

    rbm_row_mem #(
        .MAX_WIDTH  (MAX_WIDTH),
        .LABEL_BITS (LABEL_BITS)
    ) u_row_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re      (mem_re),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    rbm_edge #(
        .MAX_WIDTH  (MAX_WIDTH),
        .LABEL_BITS (LABEL_BITS)
    ) u_edge (
        .clk      (clk),
        .rst_n    (rst_n),
        .p1_ctrl  (p1_ctrl),
        .p1_x     (p1_x),
        .p1_y     (p1_y),
        .p1_down  (p1_down),
        .p1_first (p1_first),
        .p1_last  (p1_last),
        .rdata_a  (mem_rdata_a),
        .rdata_b  (mem_rdata_b),
        .out_free (out_free),
        .results  (results)
    );

endmodule

// ===== src/rbm_checker.sv =====
// ----------------------------------------------------------------------------
// Region boundary marker checker
// Port-level timing checks on the label and result channels.
// ----------------------------------------------------------------------------
`include "region_boundary_marker_defines.svh"

module rbm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        labels_valid,
    input logic                        labels_ready,
    input logic                        results_valid,
    input logic                        results_ready,
    input logic                        results_outline,
    input logic [rbm_pkg::PIX_X_W-1:0] results_pixel_x,
    input logic [rbm_pkg::PIX_Y_W-1:0] results_pixel_y,
    input logic                        results_frame_last
);
    logic label_acc;

    assign label_acc = labels_valid && labels_ready;

    `RBM_ASSERT_NEXT(a_result_hold, results_valid && !results_ready, results_valid && $stable(results_outline) && $stable(results_pixel_x) && $stable(results_pixel_y) && $stable(results_frame_last))

    `RBM_ASSERT_IMPL(a_result_from_item, $rose(results_valid), $past(label_acc, 2))

    `RBM_ASSERT_IMPL(a_stall_on_full_output, !labels_ready, results_valid && !results_ready)

endmodule

bind region_boundary_marker rbm_checker u_rbm_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .labels_valid       (labels.valid),
    .labels_ready       (labels.ready),
    .results_valid      (results.valid),
    .results_ready      (results.ready),
    .results_outline    (results.outline),
    .results_pixel_x    (results.pixel_x),
    .results_pixel_y    (results.pixel_y),
    .results_frame_last (results.frame_last)
);
